// ===== sv/rffg_pkg.sv =====
// Shared types and constants for the RGB fade frame generator.
// No dependencies; imported by rgb_fade_frame_generator.
`default_nettype none

package rffg_pkg;

    // Request kind carried in the input tuser
    localparam int REQ_W   = 3;
    // Delay field width (ticks to wait after a frame)
    localparam int DELAY_W = 8;
    // Number of color lanes (red, green, blue)
    localparam int LANES   = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK       = 3'd0,
        REQ_SET        = 3'd1,
        REQ_FADE_IN    = 3'd2,
        REQ_FADE_OUT   = 3'd3,
        REQ_FADE_INOUT = 3'd4,
        REQ_FADE_TO    = 3'd5
    } t_req;

    // Result status carried in the output tuser
    localparam logic STAT_FRAME = 1'b0;
    localparam logic STAT_BUSY  = 1'b1;

endpackage

`default_nettype wire

// ===== sv/rgb_fade_frame_generator.sv =====
// Whole-strip RGB fade frame generator: one module with bit-serial multiply/divide lanes.
// Depends on rffg_pkg (request codes, status codes, field widths).
//
//  channel  | direction | tdata (low bit up)                         | tuser    | tlast
//  ---------+-----------+--------------------------------------------+----------+-----------
//  s_axis   | in        | red, green, blue, step_count, delay_ticks  | req_type | -
//  m_axis   | out       | red_out, green_out, blue_out               | status   | last_frame
//
// After accept, a frame passes through one shift-add multiply pass over the STEP_BITS
// multiplier bits, one restoring divide pass over COLOR_BITS + STEP_BITS quotient bits and a
// load into the output register, three lanes side by side; the next word can be taken in the
// cycle after that load at the earliest.
// Ticks that cause no frame, rejections and set-color words are done on accept, with no lane pass.
// Reset is synchronous, active low, and clears all control state.
// The output register holds a word while the sink stalls; input waits only while a frame
// is being computed or while the output register is full and not being drained.
`default_nettype none

module rgb_fade_frame_generator #(
    parameter int COLOR_BITS = 8,
    parameter int STEP_BITS  = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: red_in, green_in, blue_in, step_count, delay_ticks, zero fill
    input  wire logic [((3*COLOR_BITS+STEP_BITS+rffg_pkg::DELAY_W+7)/8)*8-1:0]
                                                  i_s_axis_tdata,
    // tuser: req_type
    input  wire logic [rffg_pkg::REQ_W-1:0]       i_s_axis_tuser,
    // master side
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // tdata: red_out, green_out, blue_out, zero fill
    output logic [((3*COLOR_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    // tuser: status
    output logic                                  o_m_axis_tuser,
    output logic                                  o_m_axis_tlast
);
    import rffg_pkg::*;

    localparam int C     = COLOR_BITS;
    localparam int S     = STEP_BITS;
    localparam int W     = C + S;
    localparam int CNT_W = $clog2(W);
    localparam int ODW   = ((3*C+7)/8)*8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PUT
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;

    // effect state
    logic [C-1:0]         r_stored [LANES];
    logic [C-1:0]         r_start  [LANES];
    logic [C-1:0]         r_end    [LANES];
    logic                 r_active;
    logic                 r_inout;
    logic                 r_second;
    logic                 r_busy;
    logic [S-1:0]         r_steps;
    logic [S-1:0]         r_frame;
    logic [DELAY_W-1:0]   r_delay;
    logic [DELAY_W-1:0]   r_tick_left;

    // arithmetic lanes
    logic [S-1:0]         r_mk;
    logic [S-1:0]         r_msk;
    logic [W-1:0]         r_acc    [LANES];
    logic [S-1:0]         r_rem    [LANES];

    // output register
    logic                 r_ovalid;
    logic                 r_ostatus;
    logic                 r_olast;
    logic [C-1:0]         r_ocolor [LANES];

    logic                 out_free;
    logic                 out_load;
    logic                 accept;
    t_req                 req;
    logic [C-1:0]         in_color [LANES];
    logic [S-1:0]         in_steps;
    logic [DELAY_W-1:0]   in_delay;
    logic [C:0]           add_v    [LANES];
    logic [W-1:0]         n_mul    [LANES];
    logic [S:0]           trial    [LANES];
    logic                 ge       [LANES];
    logic [S-1:0]         n_rem    [LANES];
    logic                 frame_end;

    // Unpack the input word
    assign req         = t_req'(i_s_axis_tuser);
    assign in_color[0] = i_s_axis_tdata[C-1:0];
    assign in_color[1] = i_s_axis_tdata[2*C-1:C];
    assign in_color[2] = i_s_axis_tdata[3*C-1:2*C];
    assign in_steps    = i_s_axis_tdata[3*C+S-1:3*C];
    assign in_delay    = i_s_axis_tdata[3*C+S+DELAY_W-1:3*C+S];

    // Handshakes
    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign frame_end       = (r_frame >= r_steps);

    // Load the output register on a rejection, a set color or a finished frame
    assign out_load = (accept && (req != REQ_TICK) && (req <= REQ_FADE_TO)
                       && (r_busy || (req == REQ_SET)))
                    || ((r_state == ST_PUT) && out_free);

    // One multiply bit and one divide bit per lane per cycle
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            add_v[l] = (r_msk[S-1] ? {1'b0, r_start[l]} : '0)
                     + (r_mk[S-1]  ? {1'b0, r_end[l]}   : '0);
            n_mul[l] = {r_acc[l][W-2:0], 1'b0} + W'(add_v[l]);
            trial[l] = {r_rem[l], r_acc[l][W-1]};
            ge[l]    = (trial[l] >= {1'b0, r_steps});
            n_rem[l] = ge[l] ? S'(trial[l] - {1'b0, r_steps}) : trial[l][S-1:0];
        end
    end

    // Sequencer, effect state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_active    <= 1'b0;
            r_inout     <= 1'b0;
            r_second    <= 1'b0;
            r_busy      <= 1'b0;
            r_steps     <= '0;
            r_frame     <= '0;
            r_delay     <= '0;
            r_tick_left <= '0;
            r_ovalid    <= 1'b0;
            for (int l = 0; l < LANES; l++) begin
                r_stored[l] <= '0;
                r_start[l]  <= '0;
                r_end[l]    <= '0;
            end
        end else begin
            // drain the output register
            if (i_m_axis_tready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (req)
                            REQ_TICK: begin
                                if (r_busy) begin
                                    if (r_tick_left > DELAY_W'(1)) begin
                                        r_tick_left <= r_tick_left - DELAY_W'(1);
                                    end else begin
                                        r_tick_left <= '0;
                                        if (!r_active) begin
                                            r_busy <= 1'b0;
                                        end else begin
                                            r_msk   <= r_steps - r_frame;
                                            r_mk    <= r_frame;
                                            r_cnt   <= CNT_W'(S-1);
                                            r_state <= ST_MUL;
                                            for (int l = 0; l < LANES; l++) begin
                                                r_acc[l] <= '0;
                                            end
                                        end
                                    end
                                end
                            end
                            REQ_SET, REQ_FADE_IN, REQ_FADE_OUT, REQ_FADE_INOUT,
                            REQ_FADE_TO: begin
                                if (r_busy) begin
                                    // reject: dark, not last
                                    r_ovalid  <= 1'b1;
                                    r_ostatus <= STAT_BUSY;
                                    r_olast   <= 1'b0;
                                    for (int l = 0; l < LANES; l++) begin
                                        r_ocolor[l] <= '0;
                                    end
                                end else if (req == REQ_SET) begin
                                    r_ovalid  <= 1'b1;
                                    r_ostatus <= STAT_FRAME;
                                    r_olast   <= 1'b1;
                                    for (int l = 0; l < LANES; l++) begin
                                        r_ocolor[l] <= in_color[l];
                                    end
                                end else begin
                                    for (int l = 0; l < LANES; l++) begin
                                        r_acc[l] <= '0;
                                        if (req == REQ_FADE_OUT) begin
                                            r_start[l] <= in_color[l];
                                            r_end[l]   <= '0;
                                        end else if (req == REQ_FADE_TO) begin
                                            r_start[l]  <= r_stored[l];
                                            r_end[l]    <= in_color[l];
                                            r_stored[l] <= in_color[l];
                                        end else begin
                                            r_start[l] <= '0;
                                            r_end[l]   <= in_color[l];
                                        end
                                    end
                                    r_steps  <= in_steps;
                                    r_delay  <= in_delay;
                                    r_frame  <= '0;
                                    r_second <= 1'b0;
                                    r_inout  <= (req == REQ_FADE_INOUT);
                                    r_active <= 1'b1;
                                    r_busy   <= 1'b1;
                                    r_msk    <= in_steps;
                                    r_mk     <= '0;
                                    r_cnt    <= CNT_W'(S-1);
                                    r_state  <= ST_MUL;
                                end
                            end
                            default: begin
                                // unknown request: drop
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    // numerator = start*(steps-k) + end*k, MSB first
                    for (int l = 0; l < LANES; l++) begin
                        r_acc[l] <= n_mul[l];
                        r_rem[l] <= '0;
                    end
                    r_mk  <= {r_mk[S-2:0], 1'b0};
                    r_msk <= {r_msk[S-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(W-1);
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                ST_DIV: begin
                    // restoring divide by the step count, quotient shifts into the accumulator
                    for (int l = 0; l < LANES; l++) begin
                        r_acc[l] <= {r_acc[l][W-2:0], ge[l]};
                        r_rem[l] <= n_rem[l];
                    end
                    if (r_cnt == '0) begin
                        r_state <= ST_PUT;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                ST_PUT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= STAT_FRAME;
                        for (int l = 0; l < LANES; l++) begin
                            r_ocolor[l] <= (r_steps == '0) ? r_end[l] : r_acc[l][C-1:0];
                        end
                        // advance the sequence
                        if (frame_end) begin
                            if (r_inout && !r_second) begin
                                r_olast  <= 1'b0;
                                r_second <= 1'b1;
                                r_frame  <= '0;
                                for (int l = 0; l < LANES; l++) begin
                                    r_start[l] <= r_end[l];
                                    r_end[l]   <= '0;
                                end
                            end else begin
                                r_olast  <= 1'b1;
                                r_active <= 1'b0;
                            end
                        end else begin
                            r_olast <= 1'b0;
                            r_frame <= r_frame + S'(1);
                        end
                        r_tick_left <= (r_delay == '0) ? DELAY_W'(1) : r_delay;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output word
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = ODW'({r_ocolor[2], r_ocolor[1], r_ocolor[0]});
    assign o_m_axis_tuser  = r_ostatus;
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    // An effect in progress always keeps the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_active |-> r_busy)
        else $error("effect active while not busy");

    // The frame index never runs past the step count
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_frame <= r_steps))
        else $error("frame index beyond step count");

    // A frame leaves the put state into a full output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT) && out_free |=> (r_state == ST_IDLE) && r_ovalid)
        else $error("frame not loaded into output register");

    // A rejection carries a dark, non-final word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_ostatus == STAT_BUSY) |-> (o_m_axis_tdata == '0) && !r_olast)
        else $error("rejection word not dark");

    // No input is taken while a frame is being computed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) || (r_state == ST_DIV) |-> !o_s_axis_tready)
        else $error("input ready during computation");
`endif

endmodule

`default_nettype wire
